// File: rtl/bff_pkg.sv
package bff_pkg;

    // internal bit index width, wide enough for position plus count
    localparam int IW = 13;
    // field widths
    localparam int OPW  = 3;
    localparam int POSW = 11;
    localparam int CNTW = 12;

    // operation codes
    localparam logic [OPW-1:0] OP_SET_BIT   = 3'd0;
    localparam logic [OPW-1:0] OP_CLR_BIT   = 3'd1;
    localparam logic [OPW-1:0] OP_SET_RANGE = 3'd2;
    localparam logic [OPW-1:0] OP_CLR_RANGE = 3'd3;
    localparam logic [OPW-1:0] OP_FIND_CLR  = 3'd4;
    localparam logic [OPW-1:0] OP_FIND_SET  = 3'd5;
    localparam logic [OPW-1:0] OP_RESIZE    = 3'd6;

    // sequencer states
    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_DIV  = 5'b00010,
        S_BASE = 5'b00100,
        S_WALK = 5'b01000,
        S_DONE = 5'b10000
    } t_state;

    // per-word control for the update and search unit
    typedef struct packed {
        logic [IW-1:0] base;   // bit index of bit 0 of the current word
        logic [IW-1:0] lo;     // first bit of the written or searched span
        logic [IW-1:0] hi;     // end of the span, exclusive
        logic [IW-1:0] grow;   // first bit of the newly exposed region, ends at hi
        logic          value;  // value written into the span
        logic          want;   // bit value a search looks for
    } t_word_ctl;

endpackage

// File: rtl/bff_mem.sv
module bff_mem
    import bff_pkg::*;
#(
    parameter int WORD_BITS  = 32,
    parameter int WORD_COUNT = 64,
    parameter int AW         = 6
) (
    input  logic                 i_clk,
    input  logic                 i_rd_en,
    input  logic [AW-1:0]        i_rd_addr,
    output logic [WORD_BITS-1:0] o_rd_data,
    input  logic                 i_wr_en,
    input  logic [AW-1:0]        i_wr_addr,
    input  logic [WORD_BITS-1:0] i_wr_data
);

    logic [WORD_BITS-1:0] r_mem [WORD_COUNT];
    logic [WORD_BITS-1:0] r_rd_data;

    // one write and one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// File: rtl/bff_word.sv
module bff_word
    import bff_pkg::*;
#(
    parameter int WORD_BITS = 32,
    parameter int SW        = 5
) (
    input  t_word_ctl            i_ctl,
    input  logic [WORD_BITS-1:0] i_rd_data,
    output logic [WORD_BITS-1:0] o_wr_data,
    output logic                 o_hit,
    output logic [SW-1:0]        o_hit_bit
);

    // bits of the current word whose index is at or above x
    function automatic logic [WORD_BITS-1:0] ge_mask(input logic [IW-1:0] base,
                                                     input logic [IW-1:0] x);
        logic [IW-1:0]        d;
        logic [WORD_BITS-1:0] m;
        d = x - base;
        if (x <= base) begin
            m = {WORD_BITS{1'b1}};
        end else if (d >= IW'(WORD_BITS)) begin
            m = '0;
        end else begin
            m = {WORD_BITS{1'b1}} << d[SW-1:0];
        end
        return m;
    endfunction

    logic [WORD_BITS-1:0] w_span;
    logic [WORD_BITS-1:0] w_grow;
    logic [WORD_BITS-1:0] w_cand;

    // span and newly exposed region inside this word
    assign w_span = ge_mask(i_ctl.base, i_ctl.lo) & ~ge_mask(i_ctl.base, i_ctl.hi);
    assign w_grow = ge_mask(i_ctl.base, i_ctl.grow) & ~ge_mask(i_ctl.base, i_ctl.hi);

    // write back: span takes the value, exposed bits clear, others keep
    assign o_wr_data = (i_rd_data & ~(w_span | w_grow)) |
                       (i_ctl.value ? w_span : '0);

    // search candidates inside the span
    assign w_cand = w_span & (i_ctl.want ? i_rd_data : ~i_rd_data);
    assign o_hit  = |w_cand;

    // lowest candidate bit
    always_comb begin
        o_hit_bit = '0;
        for (int b = WORD_BITS - 1; b >= 0; b--) begin
            if (w_cand[b]) begin
                o_hit_bit = SW'(b);
            end
        end
    end

endmodule

// File: rtl/bitmap_find_first_engine.sv
// Bitmap with a logical length, kept in a word-wide memory with one read and one write port.
// Input channel: i_valid / o_stall carry one operation word (opcode, position,
// count). Output channel: o_valid / i_stall carry one result word (found,
// bit index, overflow flag, length after the operation) per operation.
// Operations that need no memory access (overflow, empty range, clear range
// starting past the length, search at or past the length, shrink, undefined
// opcode) go from S_IDLE straight to S_DONE. Operations that touch memory
// pass S_DIV (start word index), S_BASE (word address and first read), then
// S_WALK, one read-modify-write per word walked (a search only reads), and
// S_DONE to hand over the result. The walk covers 1 up to WORD_COUNT words,
// set by the word-at-a-time walk through the memory port: a range or a grow
// walks every word it covers, a search stops at the first word holding a hit.
// The block takes one operation at a time: o_stall is high from acceptance
// until the result is placed in the output register. A result waiting in the
// output register does not block acceptance of the next operation; a second
// result waits internally while i_stall holds the first.
// Reset clears the length to zero and empties the output register. There is
// no memory clearing pass: bits beyond the length are never searched, and every
// growth of the length zeros the newly exposed bits as part of its walk.
module bitmap_find_first_engine
    import bff_pkg::*;
#(
    parameter int WORD_BITS  = 32,
    parameter int WORD_COUNT = 64
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_stall,
    input  logic [OPW-1:0]  i_opcode,
    input  logic [POSW-1:0] i_position,
    input  logic [CNTW-1:0] i_count,
    output logic            o_valid,
    input  logic            i_stall,
    output logic            o_found,
    output logic [POSW-1:0] o_bit_index,
    output logic            o_overflow,
    output logic [CNTW-1:0] o_current_length
);

    localparam int AW = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1;
    localparam int SW = (WORD_BITS > 1) ? $clog2(WORD_BITS) : 1;
    localparam logic [31:0] CAP = 32'(WORD_BITS * WORD_COUNT);
    // reciprocal for the start word index, exact for indexes below 2^IW
    localparam int SH     = 24;
    localparam int RECIP  = ((1 << SH) + WORD_BITS - 1) / WORD_BITS;
    localparam int PRODW  = 40;

    t_state            r_state, n_state;
    logic [IW-1:0]     r_len, n_len;
    logic [IW-1:0]     r_start, n_start;
    logic [IW-1:0]     r_q, n_q;
    logic [AW-1:0]     r_addr, n_addr;
    logic [IW-1:0]     r_base, n_base;
    logic [IW-1:0]     r_lo, n_lo;
    logic [IW-1:0]     r_hi, n_hi;
    logic [IW-1:0]     r_grow, n_grow;
    logic              r_value, n_value;
    logic              r_want, n_want;
    logic              r_search, n_search;
    logic              r_ovf, n_ovf;
    logic              r_found, n_found;
    logic [IW-1:0]     r_idx, n_idx;
    logic              r_out_valid, n_out_valid;
    logic              r_out_found, n_out_found;
    logic [POSW-1:0]   r_out_idx, n_out_idx;
    logic              r_out_ovf, n_out_ovf;
    logic [CNTW-1:0]   r_out_len, n_out_len;

    // decoded operation
    logic              d_walk;
    logic              d_search;
    logic              d_ovf;
    logic [IW-1:0]     d_lo;
    logic [IW-1:0]     d_hi;
    logic [IW-1:0]     d_grow;
    logic [IW-1:0]     d_start;
    logic [IW-1:0]     d_len;
    logic              d_value;
    logic              d_want;
    logic [IW-1:0]     pos_x;
    logic [IW-1:0]     cnt_x;
    logic [IW-1:0]     end_bit;
    logic [IW-1:0]     end_rng;

    // memory and word unit wiring
    t_word_ctl            w_ctl;
    logic                 mem_rd_en;
    logic [AW-1:0]        mem_rd_addr;
    logic [WORD_BITS-1:0] mem_rd_data;
    logic                 mem_wr_en;
    logic [WORD_BITS-1:0] mem_wr_data;
    logic                 w_hit;
    logic [SW-1:0]        w_hit_bit;
    logic [PRODW-1:0]     div_prod;
    logic                 walk_last;

    assign pos_x   = IW'(i_position);
    assign cnt_x   = IW'(i_count);
    assign end_bit = pos_x + IW'(1);
    assign end_rng = pos_x + cnt_x;

    // operation decode against the current length
    always_comb begin
        d_walk   = 1'b0;
        d_search = 1'b0;
        d_ovf    = 1'b0;
        d_lo     = pos_x;
        d_hi     = end_rng;
        d_grow   = end_rng;
        d_start  = pos_x;
        d_len    = r_len;
        d_value  = 1'b0;
        d_want   = 1'b0;
        case (i_opcode)
            OP_SET_BIT, OP_CLR_BIT: begin
                if (32'(end_bit) > CAP) begin
                    d_ovf = 1'b1;
                end else begin
                    d_walk  = 1'b1;
                    d_value = (i_opcode == OP_SET_BIT);
                    d_hi    = end_bit;
                    d_grow  = (end_bit > r_len) ? r_len : end_bit;
                    d_len   = (end_bit > r_len) ? end_bit : r_len;
                    d_start = (end_bit > r_len && r_len < pos_x) ? r_len : pos_x;
                end
            end
            OP_SET_RANGE, OP_CLR_RANGE: begin
                if (i_count == '0) begin
                    d_walk = 1'b0;
                end else if (32'(end_rng) > CAP) begin
                    d_ovf = 1'b1;
                end else if (i_opcode == OP_CLR_RANGE && pos_x > r_len) begin
                    d_walk = 1'b0;
                end else begin
                    d_walk  = 1'b1;
                    d_value = (i_opcode == OP_SET_RANGE);
                    d_grow  = (end_rng > r_len) ? r_len : end_rng;
                    d_len   = (end_rng > r_len) ? end_rng : r_len;
                    d_start = (end_rng > r_len && r_len < pos_x) ? r_len : pos_x;
                end
            end
            OP_FIND_CLR, OP_FIND_SET: begin
                if (pos_x < r_len) begin
                    d_walk   = 1'b1;
                    d_search = 1'b1;
                    d_hi     = r_len;
                    d_want   = (i_opcode == OP_FIND_SET);
                end
            end
            OP_RESIZE: begin
                if (32'(cnt_x) > CAP) begin
                    d_ovf = 1'b1;
                end else if (cnt_x > r_len) begin
                    // grow: zero the newly exposed bits
                    d_walk  = 1'b1;
                    d_lo    = r_len;
                    d_hi    = cnt_x;
                    d_grow  = r_len;
                    d_start = r_len;
                    d_len   = cnt_x;
                end else begin
                    d_len = cnt_x;
                end
            end
            default: begin
                d_walk = 1'b0;
            end
        endcase
    end

    // start word index by reciprocal multiply
    assign div_prod = PRODW'(r_start) * PRODW'(RECIP);

    // current word is the last one of the span
    assign walk_last = ({1'b0, r_base} + (IW + 1)'(WORD_BITS)) >= {1'b0, r_hi};

    // sequencer
    always_comb begin
        n_state     = r_state;
        n_len       = r_len;
        n_start     = r_start;
        n_q         = r_q;
        n_addr      = r_addr;
        n_base      = r_base;
        n_lo        = r_lo;
        n_hi        = r_hi;
        n_grow      = r_grow;
        n_value     = r_value;
        n_want      = r_want;
        n_search    = r_search;
        n_ovf       = r_ovf;
        n_found     = r_found;
        n_idx       = r_idx;
        n_out_valid = r_out_valid;
        n_out_found = r_out_found;
        n_out_idx   = r_out_idx;
        n_out_ovf   = r_out_ovf;
        n_out_len   = r_out_len;

        // output word taken
        if (r_out_valid && !i_stall) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_len    = d_len;
                    n_start  = d_start;
                    n_lo     = d_lo;
                    n_hi     = d_hi;
                    n_grow   = d_grow;
                    n_value  = d_value;
                    n_want   = d_want;
                    n_search = d_search;
                    n_ovf    = d_ovf;
                    n_found  = 1'b0;
                    n_idx    = '0;
                    n_state  = d_walk ? S_DIV : S_DONE;
                end
            end
            S_DIV: begin
                n_q     = div_prod[SH+IW-1:SH];
                n_state = S_BASE;
            end
            S_BASE: begin
                n_addr  = AW'(r_q);
                n_base  = IW'(32'(r_q) * 32'(WORD_BITS));
                n_state = S_WALK;
            end
            S_WALK: begin
                if (r_search && w_hit) begin
                    n_found = 1'b1;
                    n_idx   = r_base + IW'(w_hit_bit);
                    n_state = S_DONE;
                end else if (walk_last) begin
                    n_state = S_DONE;
                end else begin
                    n_addr = r_addr + AW'(1);
                    n_base = r_base + IW'(WORD_BITS);
                end
            end
            S_DONE: begin
                if (!r_out_valid || !i_stall) begin
                    n_out_valid = 1'b1;
                    n_out_found = r_found;
                    n_out_idx   = r_idx[POSW-1:0];
                    n_out_ovf   = r_ovf;
                    n_out_len   = r_len[CNTW-1:0];
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_len       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_len       <= n_len;
            r_out_valid <= n_out_valid;
        end
        r_start     <= n_start;
        r_q         <= n_q;
        r_addr      <= n_addr;
        r_base      <= n_base;
        r_lo        <= n_lo;
        r_hi        <= n_hi;
        r_grow      <= n_grow;
        r_value     <= n_value;
        r_want      <= n_want;
        r_search    <= n_search;
        r_ovf       <= n_ovf;
        r_found     <= n_found;
        r_idx       <= n_idx;
        r_out_found <= n_out_found;
        r_out_idx   <= n_out_idx;
        r_out_ovf   <= n_out_ovf;
        r_out_len   <= n_out_len;
    end

    // memory port control: next word is read while the current one is written (no write during a search)
    assign mem_rd_en   = (r_state == S_BASE) || (r_state == S_WALK);
    assign mem_rd_addr = (r_state == S_BASE) ? AW'(r_q) : r_addr + AW'(1);
    assign mem_wr_en   = (r_state == S_WALK) && !r_search;

    assign w_ctl.base  = r_base;
    assign w_ctl.lo    = r_lo;
    assign w_ctl.hi    = r_hi;
    assign w_ctl.grow  = r_grow;
    assign w_ctl.value = r_value;
    assign w_ctl.want  = r_want;

    bff_mem #(
        .WORD_BITS  (WORD_BITS),
        .WORD_COUNT (WORD_COUNT),
        .AW         (AW)
    ) u_mem (
        .i_clk     (i_clk),
        .i_rd_en   (mem_rd_en),
        .i_rd_addr (mem_rd_addr),
        .o_rd_data (mem_rd_data),
        .i_wr_en   (mem_wr_en),
        .i_wr_addr (r_addr),
        .i_wr_data (mem_wr_data)
    );

    bff_word #(
        .WORD_BITS (WORD_BITS),
        .SW        (SW)
    ) u_word (
        .i_ctl     (w_ctl),
        .i_rd_data (mem_rd_data),
        .o_wr_data (mem_wr_data),
        .o_hit     (w_hit),
        .o_hit_bit (w_hit_bit)
    );

    assign o_stall          = (r_state != S_IDLE);
    assign o_valid          = r_out_valid;
    assign o_found          = r_out_found;
    assign o_bit_index      = r_out_idx;
    assign o_overflow       = r_out_ovf;
    assign o_current_length = r_out_len;

endmodule
